@@ design/tqt_pkg.sv @@
// Shared constants, request codes and control types of the task queue with timer table.
package tqt_pkg;

    localparam int QUEUE_SLOTS    = 8;
    localparam int TIMER_SLOTS    = 8;
    localparam int TASK_ID_BITS   = 8;

    localparam int REQ_BITS       = 3;
    localparam int ID_PORT_BITS   = 8;
    localparam int DELAY_BITS     = 16;

    localparam int QUEUE_IDX_BITS = $clog2(QUEUE_SLOTS);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_SLOTS + 1);
    localparam int TIMER_IDX_BITS = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam logic [REQ_BITS-1:0] REQ_POST  = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_SET   = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_DEL   = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_TICK  = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_FETCH = 3'd4;
    // Internal code for a request that changes nothing (idle id or unknown type).
    localparam logic [REQ_BITS-1:0] REQ_NONE  = 3'd7;

    localparam logic [DELAY_BITS-1:0] COUNT_FIRE = 16'd1;

    typedef struct packed {
        logic                      latch;
        logic                      walk;
        logic                      exec;
        logic                      deliver;
        logic [TIMER_IDX_BITS-1:0] slot;
    } tqt_cmd_t;

    typedef struct packed {
        logic needs_walk;
        logic out_free;
    } tqt_status_t;

endpackage

@@ design/tqt_ctrl.sv @@
// Sequencer for the dispatcher: request capture, timer slot walk, execute and deliver.
module tqt_ctrl
    import tqt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tqt_status_t status,
    output tqt_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_WALK    = 2'd1;
    localparam logic [1:0] ST_EXEC    = 2'd2;
    localparam logic [1:0] ST_DELIVER = 2'd3;

    localparam logic [TIMER_IDX_BITS-1:0] LAST_SLOT = TIMER_IDX_BITS'(TIMER_SLOTS - 1);

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [TIMER_IDX_BITS-1:0] idx_reg;
    logic [TIMER_IDX_BITS-1:0] idx_next;
    logic                      accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign cmd.latch   = accept;
    assign cmd.walk    = (state_reg == ST_WALK);
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.deliver = (state_reg == ST_DELIVER);
    assign cmd.slot    = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    state_next = status.needs_walk ? ST_WALK : ST_EXEC;
                end
            end
            ST_WALK:
            begin
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_EXEC;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                // hold until the result register can take the new result
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ design/tqt_datapath.sv @@
// Ready FIFO, timer slot table, result accumulation and output register.
module tqt_datapath
    import tqt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tqt_cmd_t                cmd,
    output tqt_status_t             status,
    input  logic [REQ_BITS-1:0]     req_type,
    input  logic [ID_PORT_BITS-1:0] task_id,
    input  logic [DELAY_BITS-1:0]   delay,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ID_PORT_BITS-1:0] next_task,
    output logic                    task_valid,
    output logic                    queue_drop,
    output logic                    timer_drop
);

    typedef logic [TASK_ID_BITS-1:0]   id_t;
    typedef logic [DELAY_BITS-1:0]     cnt_t;
    typedef logic [QUEUE_IDX_BITS-1:0] qidx_t;

    // request
    logic [REQ_BITS-1:0]       op_reg, op_next, op_in;
    id_t                       id_reg, id_next, id_in;
    cnt_t                      dly_reg, dly_next;

    // walk findings
    logic                      match_found_reg, match_found_next;
    logic [TIMER_IDX_BITS-1:0] match_idx_reg, match_idx_next;
    logic                      free_found_reg, free_found_next;
    logic [TIMER_IDX_BITS-1:0] free_idx_reg, free_idx_next;

    // ready FIFO
    id_t                       fifo_reg [QUEUE_SLOTS];
    id_t                       fifo_next [QUEUE_SLOTS];
    qidx_t                     head_reg, head_next;
    qidx_t                     tail_reg, tail_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;

    // timer table
    id_t                       task_reg [TIMER_SLOTS];
    id_t                       task_next [TIMER_SLOTS];
    cnt_t                      cnt_reg [TIMER_SLOTS];
    cnt_t                      cnt_next [TIMER_SLOTS];

    // result accumulation
    id_t                       res_task_reg, res_task_next;
    logic                      res_valid_reg, res_valid_next;
    logic                      res_qdrop_reg, res_qdrop_next;
    logic                      res_tdrop_reg, res_tdrop_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    id_t                       out_task_reg, out_task_next;
    logic                      out_tvalid_reg, out_tvalid_next;
    logic                      out_qdrop_reg, out_qdrop_next;
    logic                      out_tdrop_reg, out_tdrop_next;

    logic                      push_en;
    id_t                       push_id;
    logic                      pop_en;
    logic                      full;
    id_t                       walk_task;
    cnt_t                      walk_cnt;

    function automatic qidx_t q_adv(input qidx_t p);
        qidx_t r;
        if (p == QUEUE_IDX_BITS'(QUEUE_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign id_in = TASK_ID_BITS'(task_id);

    always_comb
    begin
        op_in = req_type;
        if (id_in == '0 && (req_type == REQ_POST || req_type == REQ_SET || req_type == REQ_DEL))
        begin
            op_in = REQ_NONE;
        end
        else if (req_type > REQ_FETCH)
        begin
            op_in = REQ_NONE;
        end
    end

    assign status.needs_walk = (op_in == REQ_SET) || (op_in == REQ_DEL) || (op_in == REQ_TICK);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign full      = (count_reg == QUEUE_CNT_BITS'(QUEUE_SLOTS));
    assign walk_task = task_reg[cmd.slot];
    assign walk_cnt  = cnt_reg[cmd.slot];

    always_comb
    begin
        op_next          = op_reg;
        id_next          = id_reg;
        dly_next         = dly_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        fifo_next        = fifo_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        task_next        = task_reg;
        cnt_next         = cnt_reg;
        res_task_next    = res_task_reg;
        res_valid_next   = res_valid_reg;
        res_qdrop_next   = res_qdrop_reg;
        res_tdrop_next   = res_tdrop_reg;
        out_valid_next   = out_valid_reg;
        out_task_next    = out_task_reg;
        out_tvalid_next  = out_tvalid_reg;
        out_qdrop_next   = out_qdrop_reg;
        out_tdrop_next   = out_tdrop_reg;
        push_en          = 1'b0;
        push_id          = '0;
        pop_en           = 1'b0;

        if (cmd.latch)
        begin
            op_next          = op_in;
            id_next          = id_in;
            dly_next         = delay;
            match_found_next = 1'b0;
            match_idx_next   = '0;
            free_found_next  = 1'b0;
            free_idx_next    = '0;
            res_task_next    = '0;
            res_valid_next   = 1'b0;
            res_qdrop_next   = 1'b0;
            res_tdrop_next   = 1'b0;
        end

        if (cmd.walk)
        begin
            case (op_reg) inside
                REQ_SET, REQ_DEL:
                begin
                    // remember the first slot holding the id and the lowest free slot
                    if (walk_task == id_reg && !match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = cmd.slot;
                    end
                    if (walk_task == '0 && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmd.slot;
                    end
                end
                REQ_TICK:
                begin
                    if (walk_task != '0)
                    begin
                        if (walk_cnt != COUNT_FIRE)
                        begin
                            cnt_next[cmd.slot] = walk_cnt - 1'b1;
                        end
                        else
                        begin
                            // fire: free the slot even when the queue drops the id
                            push_en             = 1'b1;
                            push_id             = walk_task;
                            task_next[cmd.slot] = '0;
                            cnt_next[cmd.slot]  = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.exec)
        begin
            case (op_reg)
                REQ_POST:
                begin
                    push_en = 1'b1;
                    push_id = id_reg;
                end
                REQ_SET:
                begin
                    if (match_found_reg)
                    begin
                        cnt_next[match_idx_reg] = dly_reg;
                    end
                    else if (free_found_reg)
                    begin
                        task_next[free_idx_reg] = id_reg;
                        cnt_next[free_idx_reg]  = dly_reg;
                    end
                    else
                    begin
                        res_tdrop_next = 1'b1;
                    end
                end
                REQ_DEL:
                begin
                    if (match_found_reg)
                    begin
                        task_next[match_idx_reg] = '0;
                        cnt_next[match_idx_reg]  = '0;
                    end
                end
                REQ_FETCH:
                begin
                    if (count_reg != '0)
                    begin
                        pop_en         = 1'b1;
                        res_task_next  = fifo_reg[head_reg];
                        res_valid_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (push_en)
        begin
            if (full)
            begin
                res_qdrop_next = 1'b1;
            end
            else
            begin
                fifo_next[tail_reg] = push_id;
                tail_next           = q_adv(tail_reg);
                count_next          = count_reg + 1'b1;
            end
        end

        if (pop_en)
        begin
            head_next  = q_adv(head_reg);
            count_next = count_reg - 1'b1;
        end

        if (cmd.deliver && status.out_free)
        begin
            out_valid_next  = 1'b1;
            out_task_next   = res_task_reg;
            out_tvalid_next = res_valid_reg;
            out_qdrop_next  = res_qdrop_reg;
            out_tdrop_next  = res_tdrop_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                task_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            task_reg      <= task_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        id_reg          <= id_next;
        dly_reg         <= dly_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        fifo_reg        <= fifo_next;
        res_task_reg    <= res_task_next;
        res_valid_reg   <= res_valid_next;
        res_qdrop_reg   <= res_qdrop_next;
        res_tdrop_reg   <= res_tdrop_next;
        out_task_reg    <= out_task_next;
        out_tvalid_reg  <= out_tvalid_next;
        out_qdrop_reg   <= out_qdrop_next;
        out_tdrop_reg   <= out_tdrop_next;
    end

    assign out_valid  = out_valid_reg;
    assign next_task  = ID_PORT_BITS'(out_task_reg);
    assign task_valid = out_tvalid_reg;
    assign queue_drop = out_qdrop_reg;
    assign timer_drop = out_tdrop_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_BITS'(QUEUE_SLOTS))
        else $error("ready count exceeds queue depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) ||
        (count_reg == QUEUE_CNT_BITS'($past(count_reg) + 1'b1)) ||
        (count_reg == QUEUE_CNT_BITS'($past(count_reg) - 1'b1)))
        else $error("ready count moved by more than one");

    a_rise_after_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.deliver))
        else $error("result appeared without a deliver step");

    a_fetched_nonidle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_tvalid_reg) |-> (out_task_reg != '0))
        else $error("fetch returned the idle id");

endmodule

@@ design/task_queue_with_timer_table_core.sv @@
// Post, fetch or idle request: execute, then deliver loads the output register.
// Set-timer, delete-timer or tick: slot walk, one slot per cycle, then execute and deliver.
// The slot walk sets the item time: one item in work; a new one is taken only in idle.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n low, asynchronous) empties the ready FIFO and frees every timer slot.
module task_queue_with_timer_table_core
    import tqt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [REQ_BITS-1:0]     req_type,
    input  logic [ID_PORT_BITS-1:0] task_id,
    input  logic [DELAY_BITS-1:0]   delay,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ID_PORT_BITS-1:0] next_task,
    output logic                    task_valid,
    output logic                    queue_drop,
    output logic                    timer_drop
);

    tqt_cmd_t    cmd;
    tqt_status_t status;

    tqt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tqt_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (req_type),
        .task_id    (task_id),
        .delay      (delay),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .next_task  (next_task),
        .task_valid (task_valid),
        .queue_drop (queue_drop),
        .timer_drop (timer_drop)
    );

endmodule

@@ tb/tqt_checker.sv @@
// Checker for the task queue core: predicts each reply and compares it with the output transfer.
module tqt_checker
    import tqt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [REQ_BITS-1:0]     req_type,
    input  logic [ID_PORT_BITS-1:0] task_id,
    input  logic [DELAY_BITS-1:0]   delay,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [ID_PORT_BITS-1:0] next_task,
    input  logic                    task_valid,
    input  logic                    queue_drop,
    input  logic                    timer_drop,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                      REPORT_LIMIT = 10;
    localparam logic [TASK_ID_BITS-1:0] IDLE_ID      = '0;

    typedef struct packed {
        logic [ID_PORT_BITS-1:0] next_task;
        logic                    task_valid;
        logic                    queue_drop;
        logic                    timer_drop;
    } reply_t;

    logic [TASK_ID_BITS-1:0] ready_ids [QUEUE_SLOTS];
    int                      ready_cnt;
    logic [TASK_ID_BITS-1:0] slot_id   [TIMER_SLOTS];
    logic [DELAY_BITS-1:0]   slot_cnt  [TIMER_SLOTS];
    reply_t                  due_replies [$];
    reply_t                  want;
    reply_t                  got;

    // Append to the ready list; return 1 when the id is lost to a full list.
    function automatic logic enqueue_ready(input logic [TASK_ID_BITS-1:0] id);
        if (ready_cnt >= QUEUE_SLOTS)
            return 1'b1;
        ready_ids[ready_cnt] = id;
        ready_cnt++;
        return 1'b0;
    endfunction

    function automatic reply_t serve_request(input logic [REQ_BITS-1:0]     req,
                                             input logic [ID_PORT_BITS-1:0] raw_id,
                                             input logic [DELAY_BITS-1:0]   dly);
        reply_t                  r;
        logic [TASK_ID_BITS-1:0] id;
        logic                    done;
        r    = '0;
        id   = raw_id[TASK_ID_BITS-1:0];
        done = 1'b0;
        case (req)
            REQ_POST:
            begin
                if (id != IDLE_ID)
                    r.queue_drop = enqueue_ready(id);
            end
            REQ_SET:
            begin
                if (id != IDLE_ID)
                begin
                    // Prefer the slot that already holds the id, else the lowest free one.
                    for (int i = 0; i < TIMER_SLOTS; i++)
                        if (!done && slot_id[i] == id)
                        begin
                            slot_cnt[i] = dly;
                            done        = 1'b1;
                        end
                    for (int i = 0; i < TIMER_SLOTS; i++)
                        if (!done && slot_id[i] == IDLE_ID)
                        begin
                            slot_id[i]  = id;
                            slot_cnt[i] = dly;
                            done        = 1'b1;
                        end
                    r.timer_drop = !done;
                end
            end
            REQ_DEL:
            begin
                if (id != IDLE_ID)
                    for (int i = 0; i < TIMER_SLOTS; i++)
                        if (!done && slot_id[i] == id)
                        begin
                            slot_id[i]  = IDLE_ID;
                            slot_cnt[i] = '0;
                            done        = 1'b1;
                        end
            end
            REQ_TICK:
            begin
                for (int i = 0; i < TIMER_SLOTS; i++)
                    if (slot_id[i] != IDLE_ID)
                    begin
                        if (slot_cnt[i] != COUNT_FIRE)
                            slot_cnt[i] = slot_cnt[i] - 1'b1;
                        else
                        begin
                            // Free the slot even when its id is lost.
                            if (enqueue_ready(slot_id[i]))
                                r.queue_drop = 1'b1;
                            slot_id[i]  = IDLE_ID;
                            slot_cnt[i] = '0;
                        end
                    end
            end
            REQ_FETCH:
            begin
                if (ready_cnt != 0)
                begin
                    r.next_task  = ID_PORT_BITS'(ready_ids[0]);
                    r.task_valid = 1'b1;
                    for (int i = 0; i + 1 < QUEUE_SLOTS; i++)
                        ready_ids[i] = ready_ids[i + 1];
                    ready_ids[QUEUE_SLOTS - 1] = IDLE_ID;
                    ready_cnt--;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_SLOTS; i++)
                ready_ids[i] = IDLE_ID;
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                slot_id[i]  = IDLE_ID;
                slot_cnt[i] = '0;
            end
            ready_cnt = 0;
            due_replies.delete();
            pending = 0;
        end
        else
        begin
            // Check the output transfer first: it always belongs to an older request.
            if (out_valid && out_ready)
            begin
                got = {next_task, task_valid, queue_drop, timer_drop};
                if (due_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: reply with nothing outstanding: next_task=%0d",
                                 $realtime, got.next_task,
                                 " task_valid=%b queue_drop=%b timer_drop=%b",
                                 got.task_valid, got.queue_drop, got.timer_drop);
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (got.next_task !== want.next_task || got.task_valid !== want.task_valid ||
                        got.queue_drop !== want.queue_drop || got.timer_drop !== want.timer_drop)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: reply mismatch: next_task %0d/%0d task_valid %b/%b",
                                     $realtime, want.next_task, got.next_task,
                                     want.task_valid, got.task_valid,
                                     " queue_drop %b/%b timer_drop %b/%b (expected/actual)",
                                     want.queue_drop, got.queue_drop,
                                     want.timer_drop, got.timer_drop);
                    end
                end
            end
            if (in_valid && in_ready)
                due_replies.push_back(serve_request(req_type, task_id, delay));
            pending = due_replies.size();
        end
    end

endmodule

@@ tb/tb_task_queue_with_timer_table_core.sv @@
// Testbench top for the task queue core: clock, reset, request stimulus, reply stalls and verdict.
module tb_task_queue_with_timer_table_core;
    import tqt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      HALF_PERIOD  = 10;
    localparam int      RESET_CYCLES = 9;
    localparam int      RANDOM_ITEMS = 1300;
    localparam int      QUIET_ITEMS  = 150;
    localparam int      BLOCK_ITEMS  = 50;
    localparam int      HOLD_START   = 300;
    localparam int      HOLD_CYCLES  = 300;
    localparam int      DRAIN_CYCLES = 30;
    localparam longint  TIMEOUT_NS   = 10_000_000;

    // Request codes the block treats as unknown.
    localparam logic [REQ_BITS-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_BITS-1:0] REQ_RSVD6 = 3'd6;

    typedef enum int {MODE_MIXED, MODE_FILL, MODE_TIMERS, MODE_DRAIN, MODE_NOISE} mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [REQ_BITS-1:0]     req_type;
    logic [ID_PORT_BITS-1:0] task_id;
    logic [DELAY_BITS-1:0]   delay;
    logic                    out_valid;
    logic                    out_ready;
    logic [ID_PORT_BITS-1:0] next_task;
    logic                    task_valid;
    logic                    queue_drop;
    logic                    timer_drop;
    int                      fail_count;
    int                      pending;

    int    sent_cnt  = 0;
    bit    tx_idle   = 1'b1;
    bit    rx_idle   = 1'b1;
    bit    quiet     = 1'b0;
    bit    hold_done = 1'b0;
    mode_t mode      = MODE_MIXED;

    always #HALF_PERIOD clk = ~clk;

    task_queue_with_timer_table_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .task_id    (task_id),
        .delay      (delay),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .next_task  (next_task),
        .task_valid (task_valid),
        .queue_drop (queue_drop),
        .timer_drop (timer_drop)
    );

    tqt_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .task_id    (task_id),
        .delay      (delay),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .next_task  (next_task),
        .task_valid (task_valid),
        .queue_drop (queue_drop),
        .timer_drop (timer_drop),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic issue(input logic [REQ_BITS-1:0]     req,
                         input logic [ID_PORT_BITS-1:0] id,
                         input logic [DELAY_BITS-1:0]   dly);
        if (tx_idle && !quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        task_id  <= id;
        delay    <= dly;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_cnt++;
        @(negedge clk);
    endtask

    // Mostly a small id pool so that sets and deletes hit busy slots.
    function automatic logic [ID_PORT_BITS-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return ID_PORT_BITS'($urandom_range(1, 12));
        if (roll < 90)
            return '0;
        return ID_PORT_BITS'($urandom_range(0, 255));
    endfunction

    function automatic logic [DELAY_BITS-1:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return DELAY_BITS'($urandom_range(0, 3));
        if (roll < 70)
            return DELAY_BITS'($urandom_range(0, 12));
        if (roll < 80)
            return '1;
        if (roll < 90)
            return '0;
        return DELAY_BITS'($urandom);
    endfunction

    task automatic random_item();
        int                  roll;
        logic [REQ_BITS-1:0] req;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                req = roll < 60 ? REQ_POST : roll < 75 ? REQ_SET : roll < 90 ? REQ_TICK : REQ_FETCH;
            MODE_TIMERS:
                req = roll < 35 ? REQ_SET : roll < 50 ? REQ_DEL : roll < 85 ? REQ_TICK :
                      roll < 95 ? REQ_FETCH : REQ_POST;
            MODE_DRAIN:
                req = roll < 60 ? REQ_FETCH : roll < 80 ? REQ_TICK : roll < 90 ? REQ_POST : REQ_SET;
            MODE_NOISE:
                req = REQ_BITS'($urandom_range(0, 7));
            default:
                req = roll < 20 ? REQ_POST : roll < 40 ? REQ_SET : roll < 60 ? REQ_DEL :
                      roll < 80 ? REQ_TICK : REQ_FETCH;
        endcase
        if (mode == MODE_NOISE)
            issue(req, ID_PORT_BITS'($urandom), DELAY_BITS'($urandom));
        else
            issue(req, pick_id(), pick_delay());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_POST;
        task_id  = '0;
        delay    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(REQ_FETCH, 8'd0, 16'd0);          // empty list
        issue(REQ_POST, 8'd0, 16'hFFFF);        // idle id
        issue(REQ_SET, 8'd0, 16'd5);
        issue(REQ_DEL, 8'd0, 16'd0);
        issue(REQ_RSVD5, 8'hFF, 16'hFFFF);
        issue(REQ_RSVD6, 8'h55, 16'hAAAA);
        issue(REQ_NONE, 8'hAA, 16'h5555);
        issue(REQ_POST, 8'd255, 16'd0);
        issue(REQ_POST, 8'd1, 16'd0);
        issue(REQ_SET, 8'd10, 16'd1);
        issue(REQ_SET, 8'd11, 16'd0);           // wraps on the next tick
        issue(REQ_SET, 8'd12, 16'hFFFF);
        issue(REQ_SET, 8'd13, 16'd3);
        issue(REQ_SET, 8'd13, 16'd2);           // reload of a busy slot
        issue(REQ_DEL, 8'd99, 16'd0);           // absent id
        issue(REQ_DEL, 8'd12, 16'd0);
        issue(REQ_TICK, 8'd0, 16'd0);
        issue(REQ_TICK, 8'd0, 16'd0);
        issue(REQ_FETCH, 8'd0, 16'd0);
        issue(REQ_FETCH, 8'd0, 16'd0);
        // Overfill the ready list by one.
        for (int i = 0; i < QUEUE_SLOTS - 1; i++)
            issue(REQ_POST, ID_PORT_BITS'(40 + i), 16'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % BLOCK_ITEMS == 0)
            begin
                mode    = mode_t'($urandom_range(0, 4));
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            random_item();
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[task_queue_with_timer_table_core] OK");
        else
            $display("[task_queue_with_timer_table_core] ERROR");
        $finish;
    end

    // Reply side: random stall bursts and one long hold so the input backs up.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent_cnt >= HOLD_START)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (quiet || !rx_idle)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[task_queue_with_timer_table_core] ERROR");
        $finish;
    end

endmodule

@@ task_queue_with_timer_table_core.f @@
design/tqt_pkg.sv
design/tqt_ctrl.sv
design/tqt_datapath.sv
design/task_queue_with_timer_table_core.sv
tb/tqt_checker.sv
tb/tb_task_queue_with_timer_table_core.sv
